// File: hw/rtl/ahs_pkg.sv
// ----------------------------------------------------------------------------
// ahs_pkg
// Shared constants and the arctangent table for the hillshade pipeline.
// ----------------------------------------------------------------------------
package ahs_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int SQRT_STEPS   = 31;
    localparam int DIV_BITS     = 16;

    // latency of each pipelined unit, including its input register
    localparam int SC_LAT = CORDIC_STEPS + 2;
    localparam int AT_LAT = CORDIC_STEPS + 2;
    localparam int SQ_LAT = SQRT_STEPS + 1;
    localparam int DV_LAT = DIV_BITS + 2;

    localparam int SC_W  = 34;
    localparam int VEC_W = 42;

    localparam logic signed [SC_W-1:0] KINV      = 34'sd652032874;
    localparam logic signed [SC_W-1:0] Q30_ONE   = 34'sd1073741824;
    localparam logic signed [SC_W-1:0] HALF_TURN = 34'sd2147483648;

    localparam logic [31:0] TWO_PI_Q29  = 32'd3373259426;
    localparam logic [17:0] HALF_PI_Q16 = 18'd102944;

    // register indexes of the configuration port
    localparam logic [1:0] REG_AZIMUTH = 2'd0;
    localparam logic [1:0] REG_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_EXAG    = 2'd2;
    localparam logic [1:0] REG_MODE    = 2'd3;

    // shading modes, any other code shades as standard
    localparam logic [1:0] MODE_STD   = 2'd0;
    localparam logic [1:0] MODE_CLAMP = 2'd1;
    localparam logic [1:0] MODE_SLOPE = 2'd2;

    // atan(2^-i) in 2^32 units per turn
    function automatic logic signed [SC_W-1:0] atan_step(input int i);
        case (i)
            0:  return 34'sh20000000;
            1:  return 34'sh12E4051D;
            2:  return 34'sh09FB385B;
            3:  return 34'sh051111D4;
            4:  return 34'sh028B0D43;
            5:  return 34'sh0145D7E1;
            6:  return 34'sh00A2F61E;
            7:  return 34'sh00517C55;
            8:  return 34'sh0028BE53;
            9:  return 34'sh00145F2E;
            10: return 34'sh000A2F98;
            11: return 34'sh000517CC;
            12: return 34'sh00028BE6;
            13: return 34'sh000145F3;
            14: return 34'sh0000A2F9;
            15: return 34'sh0000517C;
            16: return 34'sh000028BE;
            17: return 34'sh0000145F;
            18: return 34'sh00000A2F;
            19: return 34'sh00000517;
            20: return 34'sh0000028B;
            21: return 34'sh00000145;
            22: return 34'sh000000A2;
            23: return 34'sh00000051;
            24: return 34'sh00000028;
            25: return 34'sh00000014;
            26: return 34'sh0000000A;
            27: return 34'sh00000005;
            28: return 34'sh00000002;
            29: return 34'sh00000001;
            default: return '0;
        endcase
    endfunction

endpackage

// File: hw/rtl/ahs_sincos.sv
// ----------------------------------------------------------------------------
// ahs_sincos
// Pipelined rotation CORDIC: sine and cosine of a 2^32-per-turn angle, Q30.
// ----------------------------------------------------------------------------
module ahs_sincos #(
    parameter int SB_W = 1
) (
    input  logic                              aclk,
    input  logic                              en,
    input  logic [31:0]                       angle,
    input  logic [SB_W-1:0]                   sb_in,
    output logic signed [ahs_pkg::SC_W-1:0]   sin_out,
    output logic signed [ahs_pkg::SC_W-1:0]   cos_out,
    output logic [SB_W-1:0]                   sb_out
);

    localparam int N = ahs_pkg::CORDIC_STEPS;
    localparam int W = ahs_pkg::SC_W;

    logic signed [W-1:0] x_reg [0:N];
    logic signed [W-1:0] y_reg [0:N];
    logic signed [W-1:0] z_reg [0:N];
    logic                neg_reg [0:N];
    logic [SB_W-1:0]     sb_reg [0:N];

    logic signed [W-1:0] z_pre;
    logic                neg_pre;
    logic signed [W-1:0] sin_reg, cos_reg;
    logic [SB_W-1:0]     sb_out_reg;

    // fold into the right half plane, flipping the sign of the result
    always_comb begin
        z_pre   = W'($signed(angle));
        neg_pre = 1'b0;
        if (z_pre > ahs_pkg::Q30_ONE) begin
            z_pre   = z_pre - ahs_pkg::HALF_TURN;
            neg_pre = 1'b1;
        end else if (z_pre < -ahs_pkg::Q30_ONE) begin
            z_pre   = z_pre + ahs_pkg::HALF_TURN;
            neg_pre = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]   <= ahs_pkg::KINV;
            y_reg[0]   <= '0;
            z_reg[0]   <= z_pre;
            neg_reg[0] <= neg_pre;
            sb_reg[0]  <= sb_in;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_step
        logic signed [W-1:0] x_next, y_next, z_next;
        always_comb begin
            if (z_reg[i] >= 0) begin
                x_next = x_reg[i] - (y_reg[i] >>> i);
                y_next = y_reg[i] + (x_reg[i] >>> i);
                z_next = z_reg[i] - ahs_pkg::atan_step(i);
            end else begin
                x_next = x_reg[i] + (y_reg[i] >>> i);
                y_next = y_reg[i] - (x_reg[i] >>> i);
                z_next = z_reg[i] + ahs_pkg::atan_step(i);
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[i+1]   <= x_next;
                y_reg[i+1]   <= y_next;
                z_reg[i+1]   <= z_next;
                neg_reg[i+1] <= neg_reg[i];
                sb_reg[i+1]  <= sb_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sin_reg    <= neg_reg[N] ? -y_reg[N] : y_reg[N];
            cos_reg    <= neg_reg[N] ? -x_reg[N] : x_reg[N];
            sb_out_reg <= sb_reg[N];
        end
    end

    assign sin_out = sin_reg;
    assign cos_out = cos_reg;
    assign sb_out  = sb_out_reg;

endmodule

// File: hw/rtl/ahs_atan2.sv
// ----------------------------------------------------------------------------
// ahs_atan2
// Pipelined vectoring CORDIC: angle of (x, y), y >= 0, in 2^32 units per turn.
// ----------------------------------------------------------------------------
module ahs_atan2 #(
    parameter int SB_W = 1
) (
    input  logic                               aclk,
    input  logic                               en,
    input  logic signed [ahs_pkg::VEC_W-1:0]   x_in,
    input  logic signed [ahs_pkg::VEC_W-1:0]   y_in,
    input  logic [SB_W-1:0]                    sb_in,
    output logic [31:0]                        angle,
    output logic [SB_W-1:0]                    sb_out
);

    localparam int N  = ahs_pkg::CORDIC_STEPS;
    localparam int W  = ahs_pkg::VEC_W;
    localparam int ZW = ahs_pkg::SC_W;

    logic signed [W-1:0]  x_reg [0:N];
    logic signed [W-1:0]  y_reg [0:N];
    logic signed [ZW-1:0] z_reg [0:N];
    logic                 early_reg [0:N];
    logic                 flip_reg [0:N];
    logic [SB_W-1:0]      sb_reg [0:N];

    logic signed [ZW-1:0] z_clip, z_final;
    logic [31:0]          angle_reg;
    logic [SB_W-1:0]      sb_out_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]     <= (x_in < 0) ? -x_in : x_in;
            y_reg[0]     <= y_in;
            z_reg[0]     <= '0;
            early_reg[0] <= (y_in <= 0);
            flip_reg[0]  <= (x_in < 0);
            sb_reg[0]    <= sb_in;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_step
        logic signed [W-1:0]  x_next, y_next;
        logic signed [ZW-1:0] z_next;
        always_comb begin
            if (y_reg[i] > 0) begin
                x_next = x_reg[i] + (y_reg[i] >>> i);
                y_next = y_reg[i] - (x_reg[i] >>> i);
                z_next = z_reg[i] + ahs_pkg::atan_step(i);
            end else begin
                x_next = x_reg[i] - (y_reg[i] >>> i);
                y_next = y_reg[i] + (x_reg[i] >>> i);
                z_next = z_reg[i] - ahs_pkg::atan_step(i);
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[i+1]     <= x_next;
                y_reg[i+1]     <= y_next;
                z_reg[i+1]     <= z_next;
                early_reg[i+1] <= early_reg[i];
                flip_reg[i+1]  <= flip_reg[i];
                sb_reg[i+1]    <= sb_reg[i];
            end
        end
    end

    // clamp to a half turn, mirror for negative x, zero y short-cuts
    always_comb begin
        z_clip = z_reg[N];
        if (z_clip < 0)
            z_clip = '0;
        if (z_clip > ahs_pkg::HALF_TURN)
            z_clip = ahs_pkg::HALF_TURN;
        if (early_reg[N])
            z_final = flip_reg[N] ? ahs_pkg::HALF_TURN : '0;
        else
            z_final = flip_reg[N] ? ahs_pkg::HALF_TURN - z_clip : z_clip;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            angle_reg  <= z_final[31:0];
            sb_out_reg <= sb_reg[N];
        end
    end

    assign angle  = angle_reg;
    assign sb_out = sb_out_reg;

endmodule

// File: hw/rtl/ahs_isqrt.sv
// ----------------------------------------------------------------------------
// ahs_isqrt
// Pipelined floor square root of a value up to 2^60, one result bit a stage.
// ----------------------------------------------------------------------------
module ahs_isqrt #(
    parameter int SB_W = 1
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [60:0]       value,
    input  logic [SB_W-1:0]   sb_in,
    output logic [30:0]       root,
    output logic [SB_W-1:0]   sb_out
);

    localparam int N = ahs_pkg::SQRT_STEPS;

    logic [61:0]     v_reg [0:N];
    logic [61:0]     r_reg [0:N];
    logic [SB_W-1:0] sb_reg [0:N];

    always_ff @(posedge aclk) begin
        if (en) begin
            v_reg[0]  <= {1'b0, value};
            r_reg[0]  <= '0;
            sb_reg[0] <= sb_in;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_step
        localparam logic [61:0] BIT = 62'd1 << (60 - 2 * i);
        logic [61:0] trial, v_next, r_next;
        always_comb begin
            trial = r_reg[i] + BIT;
            if (v_reg[i] >= trial) begin
                v_next = v_reg[i] - trial;
                r_next = (r_reg[i] >> 1) + BIT;
            end else begin
                v_next = v_reg[i];
                r_next = r_reg[i] >> 1;
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                v_reg[i+1]  <= v_next;
                r_reg[i+1]  <= r_next;
                sb_reg[i+1] <= sb_reg[i];
            end
        end
    end

    assign root   = r_reg[N][30:0];
    assign sb_out = sb_reg[N];

endmodule

// File: hw/rtl/ahs_div.sv
// ----------------------------------------------------------------------------
// ahs_div
// Pipelined restoring divider with a 16-bit saturating quotient.
// ----------------------------------------------------------------------------
module ahs_div #(
    parameter int SB_W = 1
) (
    input  logic               aclk,
    input  logic               en,
    input  logic [47:0]        dividend,
    input  logic signed [35:0] divisor,
    input  logic               num_nz,
    input  logic [SB_W-1:0]    sb_in,
    output logic [15:0]        quotient,
    output logic               sat,
    output logic [SB_W-1:0]    sb_out
);

    localparam int N = ahs_pkg::DIV_BITS;

    logic [47:0]     rem_reg [0:N];
    logic [31:0]     d_reg [0:N];
    logic [N-1:0]    q_reg [0:N];
    logic            dpos_reg [0:N];
    logic            over_reg [0:N];
    logic            nz_reg [0:N];
    logic [SB_W-1:0] sb_reg [0:N];

    logic [15:0]     quot_reg;
    logic            sat_reg;
    logic [SB_W-1:0] sb_out_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= dividend;
            d_reg[0]    <= divisor[31:0];
            q_reg[0]    <= '0;
            dpos_reg[0] <= (divisor > 0);
            over_reg[0] <= (dividend >= ({16'b0, divisor[31:0]} << N));
            nz_reg[0]   <= num_nz;
            sb_reg[0]   <= sb_in;
        end
    end

    for (genvar j = 0; j < N; j++) begin : g_step
        localparam int K = N - 1 - j;
        logic [47:0] shifted;
        logic        take;
        assign shifted = {16'b0, d_reg[j]} << K;
        assign take    = (rem_reg[j] >= shifted);
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j+1]  <= take ? rem_reg[j] - shifted : rem_reg[j];
                q_reg[j+1]    <= {q_reg[j][N-2:0], take};
                d_reg[j+1]    <= d_reg[j];
                dpos_reg[j+1] <= dpos_reg[j];
                over_reg[j+1] <= over_reg[j];
                nz_reg[j+1]   <= nz_reg[j];
                sb_reg[j+1]   <= sb_reg[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sb_out_reg <= sb_reg[N];
            // non-positive divisor saturates unless the numerator is zero
            if (!dpos_reg[N]) begin
                quot_reg <= nz_reg[N] ? 16'hFFFF : 16'h0000;
                sat_reg  <= nz_reg[N];
            end else if (over_reg[N]) begin
                quot_reg <= 16'hFFFF;
                sat_reg  <= 1'b1;
            end else begin
                quot_reg <= 16'(q_reg[N]);
                sat_reg  <= 1'b0;
            end
        end
    end

    assign quotient = quot_reg;
    assign sat      = sat_reg;
    assign sb_out   = sb_out_reg;

endmodule

// File: hw/rtl/analytical_hillshade.sv
// ----------------------------------------------------------------------------
// analytical_hillshade
// Lambert hillshading of one grid cell per cycle from slope and aspect.
// ----------------------------------------------------------------------------
// The block accepts one cell every cycle unless the result port stalls;
// cells leave in the order they entered. A cell passes through a chain of
// units: three sine/cosine CORDIC pipelines in parallel, a vectoring
// CORDIC for the exaggerated slope, a second sine/cosine CORDIC, the
// products of the cosine law, a one-bit-per-stage square root, a second
// vectoring CORDIC and a 16-stage divider whose quotient only the
// slope-combined mode uses. When the result port stalls, the whole
// pipeline holds. Configuration writes are taken at any time but must
// only be made while no cell is in flight.
module analytical_hillshade #(
    parameter int ANGLE_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cell_valid,
    input  logic [13:0] s_slope_angle,
    input  logic [15:0] s_aspect_angle,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_shade_angle,
    output logic        m_no_data,
    output logic        m_saturated,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int SW   = ahs_pkg::SC_W;
    localparam int VW   = ahs_pkg::VEC_W;
    localparam int AB   = ANGLE_BITS;
    localparam int QSH  = 32 - AB;
    localparam int DROP = (AB < 16) ? 16 - AB : 0;
    localparam logic [15:0] AMASK = 16'hFFFF << DROP;
    localparam int LAT = 1 + ahs_pkg::SC_LAT + 1 + ahs_pkg::AT_LAT + 1 + ahs_pkg::SC_LAT
                         + 5 + ahs_pkg::SQ_LAT + ahs_pkg::AT_LAT + 4 + ahs_pkg::DV_LAT + 1;

    typedef struct packed {
        logic                 cv;
        logic signed [SW-1:0] ss;
        logic signed [35:0]   den;
    } cell_sb_t;

    typedef struct packed {
        cell_sb_t             base;
        logic signed [SW-1:0] sh;
        logic signed [SW-1:0] ch;
        logic signed [SW-1:0] ca;
    } trig_sb_t;

    localparam int CSB_W = $bits(cell_sb_t);
    localparam int TSB_W = $bits(trig_sb_t);

    logic en;
    logic [LAT-1:0] vld_reg;

    // configuration
    logic [15:0] azimuth_reg;
    logic [14:0] height_reg;
    logic [15:0] exag_reg;
    logic [1:0]  mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            azimuth_reg <= 16'd57344;
            height_reg  <= 15'd8192;
            exag_reg    <= 16'd1024;
            mode_reg    <= ahs_pkg::MODE_STD;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                ahs_pkg::REG_AZIMUTH: azimuth_reg <= cfg_data;
                ahs_pkg::REG_HEIGHT:  height_reg  <= cfg_data[14:0];
                ahs_pkg::REG_EXAG:    exag_reg    <= cfg_data;
                ahs_pkg::REG_MODE:    mode_reg    <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // pipeline advances unless a finished result is held
    assign en      = m_ready || !m_valid;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
    end

    assign m_valid = vld_reg[LAT-1];

    // input register: angles to 2^32 units per turn
    logic [31:0] slope32_reg, height32_reg, diff32_reg;
    logic        cv_in_reg;
    logic [15:0] diff16;

    assign diff16 = s_aspect_angle - azimuth_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            slope32_reg  <= {({2'b0, s_slope_angle} & AMASK), 16'b0};
            height32_reg <= {({1'b0, height_reg} & AMASK), 16'b0};
            diff32_reg   <= {(diff16 & AMASK), 16'b0};
            cv_in_reg    <= s_cell_valid;
        end
    end

    // first trig stage
    logic signed [SW-1:0] ss, cs, sh, ch, ca;
    logic                 cv_a;

    ahs_sincos #(.SB_W(1)) u_sc_slope (
        .aclk(aclk), .en(en), .angle(slope32_reg), .sb_in(cv_in_reg),
        .sin_out(ss), .cos_out(cs), .sb_out(cv_a)
    );

    ahs_sincos #(.SB_W(1)) u_sc_height (
        .aclk(aclk), .en(en), .angle(height32_reg), .sb_in(1'b0),
        .sin_out(sh), .cos_out(ch), .sb_out()
    );

    ahs_sincos #(.SB_W(1)) u_sc_aspect (
        .aclk(aclk), .en(en), .angle(diff32_reg), .sb_in(1'b0),
        .sin_out(), .cos_out(ca), .sb_out()
    );

    // exaggerated slope and mode 2 divisor
    logic signed [SW-1:0] ss_clip;
    logic signed [50:0]   yv_prod;
    logic signed [51:0]   den_prod;
    logic signed [VW-1:0] yv_reg, cs_reg;
    trig_sb_t             t1_sb_reg;

    assign ss_clip  = (ss < 0) ? '0 : ss;
    assign yv_prod  = $signed({1'b0, exag_reg}) * ss_clip;
    assign den_prod = cs * $signed(ahs_pkg::HALF_PI_Q16);

    always_ff @(posedge aclk) begin
        if (en) begin
            yv_reg            <= VW'(yv_prod >>> 8);
            cs_reg            <= VW'(cs);
            t1_sb_reg.base.cv <= cv_a;
            t1_sb_reg.base.ss <= ss_clip;
            t1_sb_reg.base.den <= 36'(den_prod >>> 16);
            t1_sb_reg.sh      <= sh;
            t1_sb_reg.ch      <= ch;
            t1_sb_reg.ca      <= ca;
        end
    end

    logic [31:0]      phi32;
    logic [TSB_W-1:0] at1_sb;

    ahs_atan2 #(.SB_W(TSB_W)) u_at_slope (
        .aclk(aclk), .en(en), .x_in(cs_reg), .y_in(yv_reg), .sb_in(t1_sb_reg),
        .angle(phi32), .sb_out(at1_sb)
    );

    // round the tilt angle to ANGLE_BITS
    logic [32:0]      phi_sum;
    logic [AB:0]      phi_q;
    logic [31:0]      phi_ang_reg;
    logic [TSB_W-1:0] t2_sb_reg;

    assign phi_sum = {1'b0, phi32} + (33'd1 << (QSH - 1));
    assign phi_q   = (AB + 1)'(phi_sum >> QSH);

    always_ff @(posedge aclk) begin
        if (en) begin
            phi_ang_reg <= 32'(phi_q[AB-1:0]) << QSH;
            t2_sb_reg   <= at1_sb;
        end
    end

    logic signed [SW-1:0] sp, cp;
    trig_sb_t             sc2_sb;

    ahs_sincos #(.SB_W(TSB_W)) u_sc_tilt (
        .aclk(aclk), .en(en), .angle(phi_ang_reg), .sb_in(t2_sb_reg),
        .sin_out(sp), .cos_out(cp), .sb_out(sc2_sb)
    );

    // cosine of the incidence angle and one minus its square
    logic signed [67:0]   p1_reg, p2_reg, m_reg;
    logic signed [SW-1:0] ca3_reg, t2_trunc;
    logic signed [37:0]   t1_reg;
    logic signed [38:0]   c_sum;
    logic signed [31:0]   c_clamp, c5_reg, c6_reg, c7_reg;
    logic signed [63:0]   csq_reg;
    logic [60:0]          v_reg;
    cell_sb_t             side_reg [0:4];

    assign t2_trunc = SW'(p2_reg >>> 30);
    assign c_sum    = 39'(t1_reg) + 39'(m_reg >>> 30);

    always_comb begin
        if (c_sum > 39'sd1073741824)
            c_clamp = 32'sd1073741824;
        else if (c_sum < -39'sd1073741824)
            c_clamp = -32'sd1073741824;
        else
            c_clamp = 32'(c_sum);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg      <= cp * sc2_sb.sh;
            p2_reg      <= sp * sc2_sb.ch;
            ca3_reg     <= sc2_sb.ca;
            side_reg[0] <= sc2_sb.base;
            t1_reg      <= 38'(p1_reg >>> 30);
            m_reg       <= t2_trunc * ca3_reg;
            side_reg[1] <= side_reg[0];
            c5_reg      <= c_clamp;
            side_reg[2] <= side_reg[1];
            csq_reg     <= c5_reg * c5_reg;
            c6_reg      <= c5_reg;
            side_reg[3] <= side_reg[2];
            v_reg       <= (61'd1 << 60) - csq_reg[60:0];
            c7_reg      <= c6_reg;
            side_reg[4] <= side_reg[3];
        end
    end

    logic [30:0]       sq;
    logic [32+CSB_W-1:0] sq_sb;
    logic signed [31:0] c_at;
    cell_sb_t          sq_side;

    ahs_isqrt #(.SB_W(32 + CSB_W)) u_sqrt (
        .aclk(aclk), .en(en), .value(v_reg), .sb_in({c7_reg, side_reg[4]}),
        .root(sq), .sb_out(sq_sb)
    );

    assign c_at    = sq_sb[32+CSB_W-1:CSB_W];
    assign sq_side = sq_sb[CSB_W-1:0];

    logic [31:0] ang32;
    cell_sb_t    at2_side;

    ahs_atan2 #(.SB_W(CSB_W)) u_at_shade (
        .aclk(aclk), .en(en), .x_in(VW'(c_at)), .y_in(VW'({1'b0, sq})),
        .sb_in(sq_side), .angle(ang32), .sb_out(at2_side)
    );

    // rounding, optional clamp, conversion to radians, divider operands
    logic [32:0]  ang_sum;
    logic [AB:0]  ang_q, ang_reg;
    logic [63:0]  rad_prod;
    logic [15:0]  rad9_reg, rad10_reg;
    logic [46:0]  num_reg;
    logic [47:0]  n_reg;
    logic signed [35:0] den11_reg;
    logic         nz_reg;
    logic [15:0]  rad11_reg;
    cell_sb_t     side8_reg, side9_reg, side10_reg;
    logic         cv11_reg;

    assign ang_sum  = {1'b0, ang32} + (33'd1 << (QSH - 1));
    assign rad_prod = 64'(ang_reg) * 64'(ahs_pkg::TWO_PI_Q29) + (64'd1 << (AB + 14));

    always_comb begin
        ang_q = (AB + 1)'(ang_sum >> QSH);
        if (mode_reg == ahs_pkg::MODE_CLAMP && ang_q > ((AB + 1)'(1) << (AB - 2)))
            ang_q = (AB + 1)'(1) << (AB - 2);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ang_reg    <= ang_q;
            side8_reg  <= at2_side;
            rad9_reg   <= 16'(rad_prod >> (AB + 15));
            side9_reg  <= side8_reg;
            num_reg    <= 47'(rad9_reg) * 47'(side9_reg.ss[30:0]);
            rad10_reg  <= rad9_reg;
            side10_reg <= side9_reg;
            n_reg      <= (side10_reg.den > 0)
                          ? 48'(num_reg) + 48'(side10_reg.den[31:1]) : 48'(num_reg);
            nz_reg     <= (num_reg != '0);
            den11_reg  <= side10_reg.den;
            rad11_reg  <= rad10_reg;
            cv11_reg   <= side10_reg.cv;
        end
    end

    logic [15:0] quot;
    logic        quot_sat;
    logic [16:0] dv_sb;

    ahs_div #(.SB_W(17)) u_div (
        .aclk(aclk), .en(en), .dividend(n_reg), .divisor(den11_reg), .num_nz(nz_reg),
        .sb_in({cv11_reg, rad11_reg}), .quotient(quot), .sat(quot_sat), .sb_out(dv_sb)
    );

    // result register
    logic [15:0] shade_reg;
    logic        no_data_reg, sat_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (!dv_sb[16]) begin
                shade_reg   <= '0;
                no_data_reg <= 1'b1;
                sat_reg     <= 1'b0;
            end else if (mode_reg == ahs_pkg::MODE_SLOPE) begin
                shade_reg   <= quot;
                no_data_reg <= 1'b0;
                sat_reg     <= quot_sat;
            end else begin
                shade_reg   <= dv_sb[15:0];
                no_data_reg <= 1'b0;
                sat_reg     <= 1'b0;
            end
        end
    end

    assign m_shade_angle = shade_reg;
    assign m_no_data     = no_data_reg;
    assign m_saturated   = sat_reg;

endmodule
